// File: hdl/multichannel_scalar_kalman_assert.svh
// Assertion helpers for the multichannel scalar Kalman filter.
// Both sample on the rising edge of clock and hold off while reset is high.
`ifndef MULTICHANNEL_SCALAR_KALMAN_ASSERT_SVH
`define MULTICHANNEL_SCALAR_KALMAN_ASSERT_SVH

// Check a property that holds on every clock edge.
`define MSK_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition leads to a property on the next clock edge.
`define MSK_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) cond |=> prop) else $error(msg);

`endif

// File: hdl/msk_pkg.sv
package msk_pkg;

   localparam int WORD_W           = 24;
   localparam int CHANNEL_W        = 4;
   localparam int SAMPLE_W         = 8;
   localparam int FILT_W           = 8;
   localparam int CSR_IDX_W        = 1;
   localparam int NUM_CHANNELS_DEF = 10;
   localparam int FRAC_BITS_DEF    = 16;

   localparam logic [WORD_W-1:0] WORD_MAX          = '1;
   localparam logic [WORD_W-1:0] PROCESS_NOISE_RST = 24'd65536;
   localparam logic [WORD_W-1:0] MEASURE_NOISE_RST = 24'd98304;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE = 1'd1;

   typedef struct packed {
      logic [WORD_W-1:0] estimate;
      logic [WORD_W-1:0] variance;
   } msk_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } msk_div_status_type;

endpackage

// File: hdl/multichannel_scalar_kalman.sv
// Multichannel scalar Kalman filter. Each transaction brings a channel number and an 8-bit
// sample; the block updates that channel's estimate and error variance (unsigned fixed point,
// FRAC_BITS fraction bits in 24-bit words) and returns the integer part of the new estimate,
// saturated to 255. A channel at or above NUM_CHANNELS returns channel_error with filtered 0
// and changes no state. A transaction passes through prediction, the restoring gain divider,
// which makes one quotient bit per cycle, and three passes through the shared multiplier.
// When the gain denominator is zero the divider finishes at once; a bad channel goes straight
// to the result. req_ready is high only while no transaction is in progress. A finished
// result waits in the output register without holding off the next request, but the next
// transaction cannot finish until that result has been taken.
// Estimates and variances read as zero after reset; no clearing pass is needed.
`include "multichannel_scalar_kalman_assert.svh"

module multichannel_scalar_kalman
   import msk_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHANNEL_W-1:0]  req_channel,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FILT_W-1:0]     rsp_filtered,
   output logic                  rsp_channel_error,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0]     csr_wdata
);

   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int GAIN_W = FRAC_BITS + 1;
   localparam int PROD_W = GAIN_W + WORD_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam logic [GAIN_W-1:0] ONE_GAIN = GAIN_W'(1) << FRAC_BITS;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PRED  = 8'b0000_0010,
      S_GAIN  = 8'b0000_0100,
      S_DIV   = 8'b0000_1000,
      S_MUL_X = 8'b0001_0000,
      S_MUL_S = 8'b0010_0000,
      S_MUL_P = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;

   logic [WORD_W-1:0]   q_noise_ff, q_noise_in;
   logic [WORD_W-1:0]   r_noise_ff, r_noise_in;

   logic [CH_W-1:0]     chan_ff, chan_in;
   logic                chan_err_ff, chan_err_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [WORD_W-1:0]   pm_ff, pm_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FILT_W-1:0]   rsp_filtered_ff, rsp_filtered_in;
   logic                rsp_channel_error_ff, rsp_channel_error_in;

   logic                accept;
   logic                bad_channel;
   logic                out_free;

   msk_entry_type       rd_entry;
   msk_entry_type       wr_entry;
   logic                wr_en;

   logic                div_start;
   logic [WORD_W:0]     den;
   logic [GAIN_W-1:0]   div_quot;
   msk_div_status_type  div_status;

   logic [WORD_W:0]     p_sum;
   logic [GAIN_W-1:0]   one_minus_k;
   logic [GAIN_W-1:0]   mul_a;
   logic [WORD_W-1:0]   mul_b;
   logic [PROD_W-1:0]   mul_out;
   logic [31:0]         s_wide;
   logic [WORD_W-1:0]   s_word;
   logic [ACC_W-1:0]    xn_wide;
   logic [PROD_W-1:0]   pn_wide;
   logic [WORD_W-1:0]   est_new;
   logic [WORD_W-1:0]   var_new;
   logic [WORD_W-1:0]   est_int;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign bad_channel = 7'(req_channel) >= 7'(NUM_CHANNELS);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      q_noise_in = q_noise_ff;
      r_noise_in = r_noise_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE: q_noise_in = csr_wdata;
            CSR_MEASURE_NOISE: r_noise_in = csr_wdata;
            default: ;
         endcase
      end
   end

   msk_store #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CH_W         (CH_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && !bad_channel),
      .rd_addr (CH_W'(req_channel)),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (chan_ff),
      .wr_data (wr_entry)
   );

   msk_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (pm_ff),
      .denom  (den),
      .quot   (div_quot),
      .status (div_status)
   );

   always_comb begin
      p_sum       = {1'b0, rd_entry.variance} + {1'b0, q_noise_ff};
      den         = {1'b0, pm_ff} + {1'b0, r_noise_ff};
      one_minus_k = ONE_GAIN - div_quot;
      s_wide      = 32'(sample_ff) << FRAC_BITS;
      s_word      = (s_wide > 32'(WORD_MAX)) ? WORD_MAX : s_wide[WORD_W-1:0];
      xn_wide     = acc_ff >> FRAC_BITS;
      pn_wide     = prod_ff >> FRAC_BITS;
      est_new     = (xn_wide > ACC_W'(WORD_MAX)) ? WORD_MAX : xn_wide[WORD_W-1:0];
      var_new     = (pn_wide > PROD_W'(WORD_MAX)) ? WORD_MAX : pn_wide[WORD_W-1:0];
      est_int     = est_new >> FRAC_BITS;
      wr_entry.estimate = est_new;
      wr_entry.variance = var_new;

      mul_a = one_minus_k;
      mul_b = rd_entry.estimate;
      if (state_ff == S_MUL_S) begin
         mul_a = div_quot;
         mul_b = s_word;
      end else if (state_ff == S_MUL_P) begin
         mul_b = pm_ff;
      end
      mul_out = mul_a * mul_b;
   end

   always_comb begin
      state_in             = state_ff;
      chan_in              = chan_ff;
      chan_err_in          = chan_err_ff;
      sample_in            = sample_ff;
      pm_in                = pm_ff;
      prod_in              = prod_ff;
      acc_in               = acc_ff;
      div_start            = 1'b0;
      wr_en                = 1'b0;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_filtered_in      = rsp_filtered_ff;
      rsp_channel_error_in = rsp_channel_error_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               chan_in     = CH_W'(req_channel);
               chan_err_in = bad_channel;
               sample_in   = req_sample;
               state_in    = bad_channel ? S_DONE : S_PRED;
            end
         end
         S_PRED: begin
            pm_in    = p_sum[WORD_W] ? WORD_MAX : p_sum[WORD_W-1:0];
            state_in = S_GAIN;
         end
         S_GAIN: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            prod_in  = mul_out;
            state_in = S_MUL_S;
         end
         S_MUL_S: begin
            acc_in   = ACC_W'(prod_ff);
            prod_in  = mul_out;
            state_in = S_MUL_P;
         end
         S_MUL_P: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            prod_in  = mul_out;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               wr_en                = !chan_err_ff;
               rsp_valid_in         = 1'b1;
               rsp_channel_error_in = chan_err_ff;
               if (chan_err_ff) begin
                  rsp_filtered_in = '0;
               end else begin
                  rsp_filtered_in = (est_int > WORD_W'(255)) ? FILT_W'(255)
                                                              : est_int[FILT_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         q_noise_ff   <= PROCESS_NOISE_RST;
         r_noise_ff   <= MEASURE_NOISE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         q_noise_ff   <= q_noise_in;
         r_noise_ff   <= r_noise_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff              <= chan_in;
      chan_err_ff          <= chan_err_in;
      sample_ff            <= sample_in;
      pm_ff                <= pm_in;
      prod_ff              <= prod_in;
      acc_ff               <= acc_in;
      rsp_filtered_ff      <= rsp_filtered_in;
      rsp_channel_error_ff <= rsp_channel_error_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered      = rsp_filtered_ff;
   assign rsp_channel_error = rsp_channel_error_ff;

   `MSK_ASSERT(a_gain_range, (state_ff == S_DIV && div_status.done) |-> (div_quot <= ONE_GAIN), "gain above one")
   `MSK_ASSERT(a_err_zero, (rsp_valid_ff && rsp_channel_error_ff) |-> (rsp_filtered_ff == '0), "error result carries data")
   `MSK_ASSERT_NEXT(a_accept_busy, (req_valid && req_ready), !req_ready, "ready after accept")
   `MSK_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE), "result outside done")

endmodule

// File: hdl/msk_store.sv
module msk_store
   import msk_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int CH_W         = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [CH_W-1:0]     rd_addr,
   output msk_entry_type       rd_data,
   input  logic                wr_en,
   input  logic [CH_W-1:0]     wr_addr,
   input  msk_entry_type       wr_data
);

   msk_entry_type               mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]     valid_ff;
   logic [NUM_CHANNELS-1:0]     valid_in;
   msk_entry_type               rd_data_ff;
   logic                        rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: hdl/msk_div.sv
module msk_div
   import msk_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [WORD_W-1:0]      numer,
   input  logic [WORD_W:0]        denom,
   output logic [FRAC_BITS:0]     quot,
   output msk_div_status_type     status
);

   localparam int QW    = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WORD_W:0]    rem_ff, rem_in;
   logic [WORD_W:0]    den_ff, den_in;
   logic [QW-1:0]      quot_ff, quot_in;

   logic [WORD_W+1:0]  trial;
   logic               trial_ge;
   logic [WORD_W:0]    numer_ext;
   logic               first_ge;

   always_comb begin
      numer_ext = {1'b0, numer};
      first_ge  = numer_ext >= denom;
      trial     = {rem_ff, 1'b0};
      trial_ge  = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;

      if (start) begin
         den_in = denom;
         if (denom == '0) begin
            quot_in = '0;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            quot_in = QW'(first_ge);
            rem_in  = first_ge ? (numer_ext - denom) : numer_ext;
            cnt_in  = CNT_W'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         quot_in = {quot_ff[QW-2:0], trial_ge};
         rem_in  = trial_ge ? (WORD_W+1)'(trial - {1'b0, den_ff}) : trial[WORD_W:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign quot        = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
